// ===== sv/cft_pkg.sv =====
// Shared types and constants for the coalescing flush throttle block.
`timescale 1ns / 1ps

package cft_pkg;

    localparam int CMD_W = 3;
    localparam int LEN_W = 11;
    localparam int OFF_W = 10;
    localparam int ACT_W = 2;
    localparam int CNT_W = 16;
    localparam int BUD_W = 8;
    localparam int IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_PACKET  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd4;

    localparam logic [ACT_W-1:0] ACT_BUFFER  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DIRECT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd2;

    localparam logic [IDX_W-1:0] REG_THROTTLE = 2'd0;
    localparam logic [IDX_W-1:0] REG_STALE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW   = 2'd2;
    localparam logic [IDX_W-1:0] REG_BUDGET   = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [BUD_W-1:0] BUD_MAX = {BUD_W{1'b1}};

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_TICK   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_CHUNK  = 6'b010000,
        S_WAIT   = 6'b100000
    } state_t;

endpackage

// ===== sv/coalescing_flush_throttle_top.sv =====
// Top level of the coalescing flush throttle descriptor controller.
`timescale 1ns / 1ps

// The block takes one event word at a time and is not ready until every
// descriptor that event causes has been taken. An accepted word is decoded
// in the exec state; a command with no descriptor then returns to idle,
// directly or through the tick and decide states. Descriptors are issued one
// at a time, each waiting out any output stall, since a single sequencer steps
// through them with one shared length subtract and compare unit. Configuration
// writes are always accepted and must only be issued while the block is idle.
module coalescing_flush_throttle_top
    import cft_pkg::*;
#(
    parameter int BUF_BYTES  = 240,
    parameter int MAX_PACKET = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0 up: cmd[2:0], packet_len[13:3], zero fill.
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0 up: action[1:0], chunk_offset[11:2], chunk_len[22:12], zero fill.
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int FILL_W = $clog2(BUF_BYTES + 1);
    localparam logic [LEN_W-1:0] BUF_LEN = LEN_W'(BUF_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET);

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   off_reg, off_next;
    logic               running_reg, running_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]   since_flush_reg, since_flush_next;
    logic [CNT_W-1:0]   since_window_reg, since_window_next;
    logic [BUD_W-1:0]   sent_reg, sent_next;
    logic [CNT_W-1:0]   throttle_reg, throttle_next;
    logic [CNT_W-1:0]   stale_reg, stale_next;
    logic [CNT_W-1:0]   window_reg, window_next;
    logic [BUD_W-1:0]   budget_reg, budget_next;
    logic               valid_reg, valid_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [OFF_W-1:0]   ooff_reg, ooff_next;
    logic [LEN_W-1:0]   olen_reg, olen_next;
    logic               olast_reg, olast_next;

    logic [LEN_W-1:0]   in_len;
    logic [LEN_W-1:0]   fill_len;
    logic [LEN_W-1:0]   rem;
    logic               rem_big;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {1'b0, olen_reg, ooff_reg, act_reg};
    assign m_tlast   = olast_reg;

    assign in_len   = (s_tdata[13:3] > MAX_LEN) ? MAX_LEN : s_tdata[13:3];
    assign fill_len = LEN_W'(fill_reg);
    assign rem      = len_reg - off_reg;
    assign rem_big  = (rem > BUF_LEN);

    always_comb
    begin
        state_next        = state_reg;
        ret_next          = ret_reg;
        cmd_next          = cmd_reg;
        len_next          = len_reg;
        off_next          = off_reg;
        running_next      = running_reg;
        fill_next         = fill_reg;
        since_flush_next  = since_flush_reg;
        since_window_next = since_window_reg;
        sent_next         = sent_reg;
        throttle_next     = throttle_reg;
        stale_next        = stale_reg;
        window_next       = window_reg;
        budget_next       = budget_reg;
        valid_next        = valid_reg;
        act_next          = act_reg;
        ooff_next         = ooff_reg;
        olen_next         = olen_reg;
        olast_next        = olast_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_THROTTLE: throttle_next = cfg_data;
                REG_STALE:    stale_next    = cfg_data;
                REG_WINDOW:   window_next   = cfg_data;
                REG_BUDGET:   budget_next   = cfg_data[BUD_W-1:0];
                default:      budget_next   = budget_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tdata[CMD_W-1:0];
                    len_next   = in_len;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (cmd_reg)
                    CMD_PACKET:
                    begin
                        if (running_reg && (len_reg != '0))
                        begin
                            if (len_reg >= BUF_LEN)
                            begin
                                off_next = '0;
                                if (fill_reg != '0)
                                begin
                                    valid_next = 1'b1;
                                    act_next   = ACT_BUFFER;
                                    ooff_next  = '0;
                                    olen_next  = fill_len;
                                    olast_next = 1'b0;
                                    fill_next  = '0;
                                    ret_next   = S_CHUNK;
                                    state_next = S_WAIT;
                                end
                                else
                                begin
                                    state_next = S_CHUNK;
                                end
                            end
                            else if (len_reg > (BUF_LEN - fill_len))
                            begin
                                valid_next = 1'b1;
                                act_next   = ACT_BUFFER;
                                ooff_next  = '0;
                                olen_next  = fill_len;
                                olast_next = 1'b1;
                                fill_next  = FILL_W'(len_reg);
                                ret_next   = S_IDLE;
                                state_next = S_WAIT;
                            end
                            else
                            begin
                                fill_next = FILL_W'(fill_len + len_reg);
                            end
                        end
                    end
                    CMD_TICK:
                    begin
                        if (since_flush_reg != CNT_MAX)
                        begin
                            since_flush_next = since_flush_reg + 1'b1;
                        end
                        if (since_window_reg != CNT_MAX)
                        begin
                            since_window_next = since_window_reg + 1'b1;
                        end
                        state_next = S_TICK;
                    end
                    CMD_START:
                    begin
                        running_next      = 1'b1;
                        fill_next         = '0;
                        since_flush_next  = '0;
                        since_window_next = '0;
                        sent_next         = '0;
                    end
                    CMD_STOP:
                    begin
                        if (running_reg && (fill_reg != '0))
                        begin
                            valid_next = 1'b1;
                            act_next   = ACT_BUFFER;
                            ooff_next  = '0;
                            olen_next  = fill_len;
                            olast_next = 1'b1;
                            fill_next  = '0;
                            ret_next   = S_IDLE;
                            state_next = S_WAIT;
                        end
                        running_next = 1'b0;
                    end
                    CMD_REVERSE:
                    begin
                        if (running_reg && (len_reg != '0))
                        begin
                            valid_next = 1'b1;
                            act_next   = ACT_FORWARD;
                            ooff_next  = '0;
                            olen_next  = len_reg;
                            olast_next = 1'b1;
                            ret_next   = S_IDLE;
                            state_next = S_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TICK:
            begin
                if (!running_reg || (fill_reg == '0))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    if (since_window_reg >= window_reg)
                    begin
                        since_window_next = '0;
                        sent_next         = '0;
                    end
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
                if (((since_flush_reg >= throttle_reg) && (sent_reg < budget_reg)) ||
                    (since_flush_reg >= stale_reg))
                begin
                    valid_next       = 1'b1;
                    act_next         = ACT_BUFFER;
                    ooff_next        = '0;
                    olen_next        = fill_len;
                    olast_next       = 1'b1;
                    fill_next        = '0;
                    since_flush_next = '0;
                    if (sent_reg != BUD_MAX)
                    begin
                        sent_next = sent_reg + 1'b1;
                    end
                    ret_next   = S_IDLE;
                    state_next = S_WAIT;
                end
            end
            S_CHUNK:
            begin
                valid_next = 1'b1;
                act_next   = ACT_DIRECT;
                ooff_next  = off_reg[OFF_W-1:0];
                olen_next  = rem_big ? BUF_LEN : rem;
                olast_next = !rem_big;
                off_next   = off_reg + (rem_big ? BUF_LEN : rem);
                ret_next   = rem_big ? S_CHUNK : S_IDLE;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (m_tready)
                begin
                    valid_next = 1'b0;
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ret_reg          <= S_IDLE;
            cmd_reg          <= '0;
            len_reg          <= '0;
            off_reg          <= '0;
            running_reg      <= 1'b0;
            fill_reg         <= '0;
            since_flush_reg  <= '0;
            since_window_reg <= '0;
            sent_reg         <= '0;
            throttle_reg     <= CNT_W'(50);
            stale_reg        <= CNT_W'(500);
            window_reg       <= CNT_W'(1000);
            budget_reg       <= BUD_W'(20);
            valid_reg        <= 1'b0;
            act_reg          <= '0;
            ooff_reg         <= '0;
            olen_reg         <= '0;
            olast_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ret_reg          <= ret_next;
            cmd_reg          <= cmd_next;
            len_reg          <= len_next;
            off_reg          <= off_next;
            running_reg      <= running_next;
            fill_reg         <= fill_next;
            since_flush_reg  <= since_flush_next;
            since_window_reg <= since_window_next;
            sent_reg         <= sent_next;
            throttle_reg     <= throttle_next;
            stale_reg        <= stale_next;
            window_reg       <= window_next;
            budget_reg       <= budget_next;
            valid_reg        <= valid_next;
            act_reg          <= act_next;
            ooff_reg         <= ooff_next;
            olen_reg         <= olen_next;
            olast_reg        <= olast_next;
        end
    end

endmodule
